// ===== rtl/marching_squares_contour_assert.svh =====
// Assertion macros for the marching squares contour block.
// Used by the top level; depends on nothing else.
`ifndef MARCHING_SQUARES_CONTOUR_ASSERT_SVH
`define MARCHING_SQUARES_CONTOUR_ASSERT_SVH

// The expression must never hold while out of reset.
`define MSC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
		else $error("contour block: forbidden condition seen");

// The consequent must hold in the cycle after the antecedent.
`define MSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("contour block: expected follow-up missing");

`endif

// ===== rtl/msc_pkg.sv =====
// Shared types, constants and helper functions of the marching squares contour block.
// Depends on nothing; every module imports it.
package msc_pkg;

	localparam int IDX_W = 12;

	localparam logic [2:0] REG_ISO_LEVEL = 3'd0;
	localparam logic [2:0] REG_GRID_COLS = 3'd1;
	localparam logic [2:0] REG_ORIGIN_X  = 3'd2;
	localparam logic [2:0] REG_ORIGIN_Y  = 3'd3;
	localparam logic [2:0] REG_STEP_X    = 3'd4;
	localparam logic [2:0] REG_STEP_Y    = 3'd5;

	localparam logic [3:0] MASK_NONE = 4'd0;
	localparam logic [3:0] MASK_ALL  = 4'd15;

	// Valid flag at bit 32, Q16.16 value below.
	typedef logic [32:0] smp_t;

	typedef struct packed {
		smp_t [3:0]         corner;
		logic [3:0]         mask;
		logic [IDX_W-1:0]   col_idx;
		logic [IDX_W-1:0]   row_idx;
	} job_t;

	typedef enum logic [3:0] {
		B_IDLE, B_CX, B_CY, B_CW, B_EDGE, B_DIV, B_MX, B_MY, B_MW, B_OUT
	} bst_t;

	// Edge codes: 0 = corners 0-1, 1 = 0-3, 2 = 1-2, 3 = 2-3.
	function automatic logic [1:0] edge_a(input logic [1:0] e);
		case (e)
			2'd0: edge_a = 2'd0;
			2'd1: edge_a = 2'd0;
			2'd2: edge_a = 2'd1;
			default: edge_a = 2'd2;
		endcase
	endfunction

	function automatic logic [1:0] edge_b(input logic [1:0] e);
		case (e)
			2'd0: edge_b = 2'd1;
			2'd1: edge_b = 2'd3;
			2'd2: edge_b = 2'd2;
			default: edge_b = 2'd3;
		endcase
	endfunction

	function automatic logic [1:0] seg_first(input logic [3:0] m);
		case (m)
			4'd3, 4'd12: seg_first = 2'd2;
			4'd4, 4'd11: seg_first = 2'd3;
			4'd7, 4'd8:  seg_first = 2'd1;
			default:     seg_first = 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] seg_second(input logic [3:0] m);
		case (m)
			4'd1, 4'd14, 4'd3, 4'd12: seg_second = 2'd1;
			4'd2, 4'd13, 4'd4, 4'd11: seg_second = 2'd2;
			default:                  seg_second = 2'd3;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sd2147483647) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (v < -48'sd2147483648) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	function automatic logic [32:0] absdiff(input logic signed [31:0] pa,
			input logic signed [31:0] pb);
		logic signed [32:0] d;
		d = 33'(pb) - 33'(pa);
		absdiff = d[32] ? 33'(-d) : 33'(d);
	endfunction

	// pa moved toward pb by round(|pb - pa| * t / 2^31), the product given.
	function automatic logic signed [31:0] lerp_pt(input logic signed [31:0] pa,
			input logic signed [31:0] pb, input logic signed [67:0] prod);
		logic signed [32:0] d;
		logic [65:0]        s;
		logic [32:0]        off;
		logic signed [33:0] r;
		d = 33'(pb) - 33'(pa);
		s = prod[65:0] + (66'd1 << 30);
		off = s[63:31];
		r = d[32] ? 34'(pa) - $signed({1'b0, off}) : 34'(pa) + $signed({1'b0, off});
		lerp_pt = r[31:0];
	endfunction

endpackage

// ===== rtl/marching_squares_contour.sv =====
// Top level of the marching squares contour block: configuration registers and the
// front end, cell queue and back end. Depends on msc_pkg, msc_front, msc_jobq, msc_back.
//
//   Channel   Handshake              Carries
//   samples   push / full            sample_value, sample_valid, frame_start
//   segments  empty / pop            start_x, start_y, end_x, end_y, cell_col, cell_row
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front end takes the sample transaction and the line-store read in one step, then
// classifies the cell and writes the store back, and takes no new sample until then.
// A cell with a segment occupies the back end while it fetches the cell and forms the grid
// coordinates, works each edge in turn and loads the result register, with a 31-step
// division on the shared divider for each edge whose crossing lies strictly inside.
// Cells with no crossing never reach the back end; a two-entry cell queue lets
// the front end run ahead while the back end works or waits on a full result register.
// Reset clears the counters, neighbors and control; the line store is not cleared and
// takes no clearing pass, since every entry is written in a row before it is read.
`include "marching_squares_contour_assert.svh"

module marching_squares_contour #(
	parameter int MAX_COLS = 512,
	parameter int MAX_ROWS = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic signed [31:0]  sample_value,
	input  logic                sample_valid,
	input  logic                frame_start,
	output logic                empty,
	input  logic                pop,
	output logic signed [31:0]  start_x,
	output logic signed [31:0]  start_y,
	output logic signed [31:0]  end_x,
	output logic signed [31:0]  end_y,
	output logic [8:0]          cell_col,
	output logic [8:0]          cell_row,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import msc_pkg::*;

	logic signed [31:0] iso_level_q, origin_x_q, origin_y_q, step_x_q, step_y_q;
	logic [9:0]         grid_cols_q;

	logic  q_push, q_pop, q_full, q_empty;
	job_t  q_wdata, q_rdata;

	// Register writes are always taken; cfg_ready is tied high.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_level_q <= 32'sd0;
			grid_cols_q <= 10'd300;
			origin_x_q  <= 32'sd0;
			origin_y_q  <= 32'sd0;
			step_x_q    <= 32'sd65536;
			step_y_q    <= 32'sd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ISO_LEVEL: iso_level_q <= cfg_data;
				REG_GRID_COLS: grid_cols_q <= cfg_data[9:0];
				REG_ORIGIN_X:  origin_x_q  <= cfg_data;
				REG_ORIGIN_Y:  origin_y_q  <= cfg_data;
				REG_STEP_X:    step_x_q    <= cfg_data;
				REG_STEP_Y:    step_y_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The front end classifies each closed cell and queues those that cross the level.
	msc_front #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample_value (sample_value),
		.sample_valid (sample_valid),
		.frame_start  (frame_start),
		.iso_level    (iso_level_q),
		.grid_cols    (grid_cols_q),
		.q_full       (q_full),
		.job_push     (q_push),
		.job          (q_wdata)
	);

	msc_jobq u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wdata   (q_wdata),
		.rd      (q_pop),
		.rdata   (q_rdata),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	// The back end turns a queued cell into one segment and holds it for the pop transaction.
	msc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.iso_level (iso_level_q),
		.origin_x  (origin_x_q),
		.origin_y  (origin_y_q),
		.step_x    (step_x_q),
		.step_y    (step_y_q),
		.job_valid (~q_empty),
		.job       (q_rdata),
		.job_pop   (q_pop),
		.pop       (pop),
		.empty     (empty),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.cell_col  (cell_col),
		.cell_row  (cell_row)
	);

	// The cell queue is never written while full unless also read, nor read while empty.
	`MSC_ASSERT_NEVER(a_q_overflow, clk, arst_n, q_push && q_full && !q_pop)
	`MSC_ASSERT_NEVER(a_q_underflow, clk, arst_n, q_pop && q_empty)
	// A sample transaction keeps the front end busy for the following cycle.
	`MSC_ASSERT_NEXT(a_front_busy, clk, arst_n, push && !full, full)

endmodule

// ===== rtl/msc_front.sv =====
// Front end: accepts samples, keeps the line store and neighbors, classifies cells.
// Depends on msc_pkg.
module msc_front #(
	parameter int MAX_COLS = 512,
	parameter int MAX_ROWS = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic signed [31:0]  sample_value,
	input  logic                sample_valid,
	input  logic                frame_start,
	input  logic signed [31:0]  iso_level,
	input  logic [9:0]          grid_cols,
	input  logic                q_full,
	output logic                job_push,
	output msc_pkg::job_t       job
);
	import msc_pkg::*;

	localparam int CW = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
	localparam int RW = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
	localparam logic [15:0] MAX_COLS_W = 16'(MAX_COLS);
	localparam logic [15:0] MAX_ROWS_W = 16'(MAX_ROWS);

	smp_t            mem [MAX_COLS];
	smp_t            rd_q;
	smp_t            cur_s1;
	logic [CW-1:0]   c_s1;
	logic [RW-1:0]   r_s1;
	logic            vld_s1;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	smp_t            left_q;
	smp_t            ul_q;

	logic            accept;
	logic [CW-1:0]   c_idx;
	logic [RW-1:0]   r_idx;
	logic [15:0]     cols;
	logic [15:0]     c_next;
	logic [15:0]     r_next;
	logic [3:0]      mask;
	smp_t [3:0]      crn;

	assign full   = vld_s1 | q_full;
	assign accept = push & ~full;
	assign c_idx  = frame_start ? '0 : col_q;
	assign r_idx  = frame_start ? '0 : row_q;

	always_comb begin
		cols = 16'(grid_cols);
		if (cols < 16'd2) begin
			cols = 16'd2;
		end
		if (cols > MAX_COLS_W) begin
			cols = MAX_COLS_W;
		end
		c_next = 16'(c_idx) + 16'd1;
		r_next = 16'(r_idx) + 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
			ul_q   <= '0;
		end else begin
			vld_s1 <= accept;
			if (accept) begin
				if (c_next >= cols) begin
					col_q <= '0;
					row_q <= (r_next >= MAX_ROWS_W) ? '0 : r_next[RW-1:0];
				end else begin
					col_q <= c_next[CW-1:0];
					row_q <= r_idx;
				end
			end
			if (vld_s1) begin
				ul_q   <= rd_q;
				left_q <= cur_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q   <= mem[c_idx];
			cur_s1 <= {sample_valid, sample_value};
			c_s1   <= c_idx;
			r_s1   <= r_idx;
		end
		if (vld_s1) begin
			mem[c_s1] <= cur_s1;
		end
	end

	always_comb begin
		crn[0] = ul_q;
		crn[1] = rd_q;
		crn[2] = cur_s1;
		crn[3] = left_q;
		for (int k = 0; k < 4; k++) begin
			mask[k] = crn[k][32] & ($signed(crn[k][31:0]) >= iso_level);
		end
		job.corner  = crn;
		job.mask    = mask;
		job.col_idx = IDX_W'(c_s1 - 1'b1);
		job.row_idx = IDX_W'(r_s1 - 1'b1);
		job_push = vld_s1 && (c_s1 != '0) && (r_s1 != '0)
			&& (mask != MASK_NONE) && (mask != MASK_ALL);
	end

endmodule

// ===== rtl/msc_jobq.sv =====
// Two-entry queue of classified cells between the front end and the back end.
// Depends on msc_pkg.
module msc_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  msc_pkg::job_t  wdata,
	input  logic           rd,
	output msc_pkg::job_t  rdata,
	output logic           q_full,
	output logic           q_empty
);
	import msc_pkg::*;

	job_t        ent_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;

	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign rdata   = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wp_q] <= wdata;
		end
	end

endmodule

// ===== rtl/msc_back.sv =====
// Back end: grid coordinates, edge interpolation with a shared divider and multiplier,
// and the result register. Depends on msc_pkg.
module msc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [31:0]  iso_level,
	input  logic signed [31:0]  origin_x,
	input  logic signed [31:0]  origin_y,
	input  logic signed [31:0]  step_x,
	input  logic signed [31:0]  step_y,
	input  logic                job_valid,
	input  msc_pkg::job_t       job,
	output logic                job_pop,
	input  logic                pop,
	output logic                empty,
	output logic signed [31:0]  start_x,
	output logic signed [31:0]  start_y,
	output logic signed [31:0]  end_x,
	output logic signed [31:0]  end_y,
	output logic [8:0]          cell_col,
	output logic [8:0]          cell_row
);
	import msc_pkg::*;

	bst_t                st_q, st_nxt;
	job_t                job_q;
	logic                edge_q;
	logic signed [31:0]  xl_q, xr_q, yt_q, yb_q;
	logic signed [31:0]  pax_q, pbx_q, pay_q, pby_q;
	logic [33:0]         rem_q;
	logic [32:0]         ud_q;
	logic [31:0]         t_q;
	logic [4:0]          cnt_q;
	logic signed [67:0]  mul_q;
	logic signed [31:0]  ptx_q, sx_q, sy_q, ex_q, ey_q;
	logic                out_valid_q;
	logic signed [31:0]  start_x_q, start_y_q, end_x_q, end_y_q;
	logic [8:0]          cell_col_q, cell_row_q;

	logic signed [33:0]  mul_a, mul_b;
	logic                out_load;
	logic [1:0]          ecode, ca, cb;
	smp_t                sa, sb;
	logic signed [33:0]  num, den;
	logic [32:0]         un, ud;
	logic                degen;
	logic                use_div;
	logic [33:0]         r2;
	logic signed [31:0]  px [4];
	logic signed [31:0]  py [4];
	logic signed [47:0]  psum;

	// Edge set-up for the edge being worked on, the divider's shifted remainder and the coordinate sum.
	always_comb begin
		ecode = edge_q ? seg_second(job_q.mask) : seg_first(job_q.mask);
		ca = edge_a(ecode);
		cb = edge_b(ecode);
		sa = job_q.corner[ca];
		sb = job_q.corner[cb];
		num = 34'(iso_level) - 34'($signed(sa[31:0]));
		den = 34'($signed(sb[31:0])) - 34'($signed(sa[31:0]));
		un = num[33] ? 33'(-num) : 33'(num);
		ud = den[33] ? 33'(-den) : 33'(den);
		if (un > ud) begin
			un = ud;
		end
		degen = !sa[32] || !sb[32] || (den == '0) || (num == '0) || (num[33] != den[33]);
		use_div = !degen && (un != ud);
		px[0] = xl_q; px[1] = xr_q; px[2] = xr_q; px[3] = xl_q;
		py[0] = yt_q; py[1] = yt_q; py[2] = yb_q; py[3] = yb_q;
		r2 = {rem_q[32:0], 1'b0};
		psum = 48'(st_q == B_CY ? origin_x : origin_y) + mul_q[47:0];
	end

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			B_IDLE: if (job_valid) st_nxt = B_CX;
			B_CX:   st_nxt = B_CY;
			B_CY:   st_nxt = B_CW;
			B_CW:   st_nxt = B_EDGE;
			B_EDGE: st_nxt = use_div ? B_DIV : B_MX;
			B_DIV:  if (cnt_q == 5'd0) st_nxt = B_MX;
			B_MX:   st_nxt = B_MY;
			B_MY:   st_nxt = B_MW;
			B_MW:   st_nxt = edge_q ? B_OUT : B_EDGE;
			B_OUT:  if (out_load) st_nxt = B_IDLE;
			default: st_nxt = B_IDLE;
		endcase
	end

	always_comb begin
		job_pop  = (st_q == B_IDLE) && job_valid;
		out_load = (st_q == B_OUT) && (!out_valid_q || pop);
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			B_CX: begin
				mul_a = $signed(34'(job_q.col_idx));
				mul_b = 34'(step_x);
			end
			B_CY: begin
				mul_a = $signed(34'(job_q.row_idx));
				mul_b = 34'(step_y);
			end
			B_MX: begin
				mul_a = $signed({1'b0, absdiff(pax_q, pbx_q)});
				mul_b = $signed({2'b00, t_q});
			end
			B_MY: begin
				mul_a = $signed({1'b0, absdiff(pay_q, pby_q)});
				mul_b = $signed({2'b00, t_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			out_valid_q <= 1'b0;
			edge_q      <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (job_pop) begin
				edge_q <= 1'b0;
			end else if (st_q == B_MW) begin
				edge_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (job_pop) begin
			job_q <= job;
		end
		case (st_q)
			B_CY: begin
				xl_q <= sat32(psum);
				xr_q <= sat32(psum + 48'(step_x));
			end
			B_CW: begin
				yt_q <= sat32(psum);
				yb_q <= sat32(psum + 48'(step_y));
			end
			B_EDGE: begin
				pax_q <= px[ca];
				pbx_q <= px[cb];
				pay_q <= py[ca];
				pby_q <= py[cb];
				rem_q <= 34'(un);
				ud_q  <= ud;
				cnt_q <= 5'd30;
				t_q   <= (!degen && (un == ud)) ? 32'h8000_0000 : 32'd0;
			end
			B_DIV: begin
				// One quotient bit per cycle, restoring form.
				if (r2 >= 34'(ud_q)) begin
					rem_q <= r2 - 34'(ud_q);
					t_q   <= {t_q[30:0], 1'b1};
				end else begin
					rem_q <= r2;
					t_q   <= {t_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q - 5'd1;
			end
			B_MY: begin
				ptx_q <= lerp_pt(pax_q, pbx_q, mul_q);
			end
			B_MW: begin
				if (!edge_q) begin
					sx_q <= ptx_q;
					sy_q <= lerp_pt(pay_q, pby_q, mul_q);
				end else begin
					ex_q <= ptx_q;
					ey_q <= lerp_pt(pay_q, pby_q, mul_q);
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			start_x_q  <= sx_q;
			start_y_q  <= sy_q;
			end_x_q    <= ex_q;
			end_y_q    <= ey_q;
			cell_col_q <= job_q.col_idx[8:0];
			cell_row_q <= job_q.row_idx[8:0];
		end
	end

	assign empty    = ~out_valid_q;
	assign start_x  = start_x_q;
	assign start_y  = start_y_q;
	assign end_x    = end_x_q;
	assign end_y    = end_y_q;
	assign cell_col = cell_col_q;
	assign cell_row = cell_row_q;

endmodule

// ===== test/marching_squares_contour_tb.sv =====
// Self-checking testbench of the marching squares contour block.
// Depends on msc_pkg and the marching_squares_contour top level; nothing else.
module marching_squares_contour_tb;
	import msc_pkg::*;

	localparam int MAX_COLS   = 512;
	localparam int MAX_ROWS   = 512;
	localparam int LIMIT      = 3000000;
	localparam int DRAIN_WAIT = 400;

	// One input sample as it travels to the block.
	typedef struct {
		logic signed [31:0] value;
		logic               ok;
		logic               first;
	} sample_t;

	// One contour segment as the block reports it.
	typedef struct {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic [8:0]         col;
		logic [8:0]         row;
	} segment_t;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic signed [31:0] sample_value;
	logic               sample_valid;
	logic               frame_start;
	logic               empty;
	logic               pop;
	logic signed [31:0] start_x;
	logic signed [31:0] start_y;
	logic signed [31:0] end_x;
	logic signed [31:0] end_y;
	logic [8:0]         cell_col;
	logic [8:0]         cell_row;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;

	marching_squares_contour DUT (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.sample_value(sample_value), .sample_valid(sample_valid), .frame_start(frame_start),
		.empty(empty), .pop(pop),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.cell_col(cell_col), .cell_row(cell_row),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Samples waiting for the driver, and segments the block still owes us.
	sample_t  pending_samples[$];
	segment_t owed_segments[$];

	int  errors = 0;
	int  cycles = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  recv_hold = 0;
	logic sent;

	// Shadow copy of the configuration, updated when a config transaction completes.
	logic signed [31:0] m_iso, m_ox, m_oy, m_sx, m_sy;
	logic [9:0]         m_cols;

	// Shadow copy of the block's line store, neighbors and raster position.
	logic [32:0] row_mem[MAX_COLS];
	logic [32:0] left_smp, upleft_smp;
	int          col_pos, row_pos;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog: the run can never legitimately take this long.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("marching_squares_contour_tb: errors");
			$finish;
		end
	end

	function automatic longint sat_coord(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Point where the contour crosses the edge from corner a to corner b. An edge that
	// touches an invalid sample, has equal ends, or has the level at or before a stays at a; a level past b gives b.
	function automatic longint crossing(input longint pa, input longint pb,
			input logic [32:0] sa, input logic [32:0] sb, input longint lvl);
		longint     va, vb, num, den, diff;
		logic [63:0] un, ud, t, ad, off;
		if (!sa[32] || !sb[32]) begin
			return pa;
		end
		va = longint'($signed(sa[31:0]));
		vb = longint'($signed(sb[31:0]));
		num = lvl - va;
		den = vb - va;
		if (den == 0 || num == 0 || ((num < 0) != (den < 0))) begin
			return pa;
		end
		un = (num < 0) ? -num : num;
		ud = (den < 0) ? -den : den;
		if (un > ud) begin
			un = ud;
		end
		t = (un << 31) / ud;
		diff = pb - pa;
		ad = (diff < 0) ? -diff : diff;
		off = (ad * t + (64'd1 << 30)) >> 31;
		return (diff < 0) ? pa - longint'(off) : pa + longint'(off);
	endfunction

	// Corner order: 0 upper-left, 1 upper, 2 current, 3 left. Edge codes:
	// 0 = corners 0-1, 1 = 0-3, 2 = 1-2, 3 = 2-3.
	function automatic int edge_lo(input int e);
		return (e == 2) ? 1 : (e == 3) ? 2 : 0;
	endfunction

	function automatic int edge_hi(input int e);
		return (e == 0) ? 1 : (e == 2) ? 2 : 3;
	endfunction

	function automatic int first_edge(input int m);
		case (m)
			3, 12: return 2;
			4, 11: return 3;
			7, 8: return 1;
			default: return 0;
		endcase
	endfunction

	function automatic int second_edge(input int m);
		case (m)
			1, 14, 3, 12: return 1;
			2, 13, 4, 11: return 2;
			default: return 3;
		endcase
	endfunction

	// Append one sample to the driver's queue.
	task automatic queue_sample(input sample_t s);
		pending_samples = {pending_samples, s};
	endtask

	// Advance the shadow state by one accepted sample and queue its segment, if any.
	task automatic track_sample(input sample_t s);
		logic [32:0] cur, up;
		logic [32:0] v[4];
		longint      px[4], py[4], pts[4];
		longint      lvl, xl, xr, yt, yb;
		int          cols, c, r, m, k, e, a, b;
		segment_t    seg;
		if (s.first) begin
			col_pos = 0;
			row_pos = 0;
		end
		cols = m_cols;
		if (cols < 2) begin
			cols = 2;
		end
		if (cols > MAX_COLS) begin
			cols = MAX_COLS;
		end
		if (col_pos >= MAX_COLS) begin
			col_pos = 0;
		end
		if (row_pos >= MAX_ROWS) begin
			row_pos = 0;
		end
		c = col_pos;
		r = row_pos;
		cur = {s.ok, s.value};
		up = row_mem[c];
		if (r >= 1 && c >= 1) begin
			lvl = longint'(m_iso);
			v[0] = upleft_smp;
			v[1] = up;
			v[2] = cur;
			v[3] = left_smp;
			m = 0;
			for (k = 0; k < 4; k++) begin
				if (v[k][32] && longint'($signed(v[k][31:0])) >= lvl) begin
					m = m | (1 << k);
				end
			end
			if (m != MASK_NONE && m != MASK_ALL) begin
				xl = sat_coord(longint'(m_ox) + longint'(c - 1) * longint'(m_sx));
				xr = sat_coord(longint'(m_ox) + longint'(c) * longint'(m_sx));
				yt = sat_coord(longint'(m_oy) + longint'(r - 1) * longint'(m_sy));
				yb = sat_coord(longint'(m_oy) + longint'(r) * longint'(m_sy));
				px[0] = xl; px[1] = xr; px[2] = xr; px[3] = xl;
				py[0] = yt; py[1] = yt; py[2] = yb; py[3] = yb;
				for (k = 0; k < 2; k++) begin
					e = (k == 0) ? first_edge(m) : second_edge(m);
					a = edge_lo(e);
					b = edge_hi(e);
					pts[2*k] = crossing(px[a], px[b], v[a], v[b], lvl);
					pts[2*k+1] = crossing(py[a], py[b], v[a], v[b], lvl);
				end
				seg.sx = pts[0][31:0];
				seg.sy = pts[1][31:0];
				seg.ex = pts[2][31:0];
				seg.ey = pts[3][31:0];
				seg.col = 9'(c - 1);
				seg.row = 9'(r - 1);
				owed_segments = {owed_segments, seg};
			end
		end
		upleft_smp = up;
		left_smp = cur;
		row_mem[c] = cur;
		col_pos = c + 1;
		if (col_pos >= cols) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= MAX_ROWS) begin
				row_pos = 0;
			end
		end
	endtask

	// Sampling at the rising edge: track accepted samples and check popped segments.
	always @(posedge clk) begin
		segment_t want;
		sent <= arst_n && push && !full;
		if (arst_n && push && !full) begin
			track_sample('{sample_value, sample_valid, frame_start});
		end
		if (arst_n && pop && !empty) begin
			if (owed_segments.size() == 0) begin
				$error("segment with no expectation: col %0d row %0d", cell_col, cell_row);
				errors++;
			end else begin
				want = owed_segments.pop_front();
				if (start_x !== want.sx) begin
					$error("start_x expected %0d actual %0d", want.sx, start_x);
					errors++;
				end
				if (start_y !== want.sy) begin
					$error("start_y expected %0d actual %0d", want.sy, start_y);
					errors++;
				end
				if (end_x !== want.ex) begin
					$error("end_x expected %0d actual %0d", want.ex, end_x);
					errors++;
				end
				if (end_y !== want.ey) begin
					$error("end_y expected %0d actual %0d", want.ey, end_y);
					errors++;
				end
				if (cell_col !== want.col) begin
					$error("cell_col expected %0d actual %0d", want.col, cell_col);
					errors++;
				end
				if (cell_row !== want.row) begin
					$error("cell_row expected %0d actual %0d", want.row, cell_row);
					errors++;
				end
			end
		end
	end

	// Sample driver: a sample stays on the bus until its transaction completes, then
	// the next one is loaded unless the sender chooses to idle this cycle.
	always @(negedge clk) begin
		sample_t s;
		if (arst_n && (!push || sent)) begin
			if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s = pending_samples.pop_front();
				push <= 1'b1;
				sample_value <= s.value;
				sample_valid <= s.ok;
				frame_start <= s.first;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Segment receiver: random stalls, plus a long hold-off when one is requested.
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		case (idx)
			REG_ISO_LEVEL: m_iso = val;
			REG_GRID_COLS: m_cols = val[9:0];
			REG_ORIGIN_X: m_ox = val;
			REG_ORIGIN_Y: m_oy = val;
			REG_STEP_X: m_sx = val;
			default: m_sy = val;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_grid(input logic [31:0] lvl, input logic [31:0] cols,
			input logic [31:0] ox, input logic [31:0] oy,
			input logic [31:0] sx, input logic [31:0] sy);
		write_reg(REG_ISO_LEVEL, lvl);
		write_reg(REG_GRID_COLS, cols);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_STEP_X, sx);
		write_reg(REG_STEP_Y, sy);
	endtask

	function automatic sample_t rand_sample(input logic signed [31:0] lvl);
		sample_t s;
		int      pick;
		pick = $urandom_range(99);
		if (pick < 60) begin
			// Close to the level, so that cells straddle it often.
			s.value = lvl + $signed(32'($urandom_range(262143))) - 32'sd131072;
		end else if (pick < 70) begin
			s.value = lvl;
		end else begin
			s.value = $urandom;
		end
		s.ok = ($urandom_range(99) >= 8);
		s.first = ($urandom_range(199) == 0);
		return s;
	endfunction

	// Queue a batch of random samples; the first opens a new frame when asked.
	task automatic queue_random(input int n, input bit open_frame);
		sample_t s;
		for (int i = 0; i < n; i++) begin
			s = rand_sample(m_iso);
			if (i == 0) begin
				s.first = open_frame;
			end
			queue_sample(s);
		end
	endtask

	// Wait until every queued sample is taken and every owed segment has arrived,
	// then let the block settle before the next configuration is written.
	task automatic drain;
		while (pending_samples.size() > 0 || push || owed_segments.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	initial begin
		sample_t d;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		sample_value = '0;
		sample_valid = 1'b0;
		frame_start = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_ISO_LEVEL;
		cfg_data = '0;
		m_iso = 0;
		m_cols = 10'd300;
		m_ox = 0;
		m_oy = 0;
		m_sx = 32'sd65536;
		m_sy = 32'sd65536;
		left_smp = '0;
		upleft_smp = '0;
		col_pos = 0;
		row_pos = 0;
		for (int i = 0; i < MAX_COLS; i++) begin
			row_mem[i] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// First stretch: sender idles a little, receiver a lot.
		send_idle_pct = 16;
		recv_idle_pct = 69;

		// Directed frame, three samples per row: extreme values, invalid samples, values
		// exactly on the level and equal corners, so that every edge case of the
		// interpolation and several corner masks show up.
		set_grid(32'd0, 32'd3, 32'd0, 32'd0, 32'sd65536, 32'sd65536);
		queue_sample('{32'sh8000_0000, 1'b1, 1'b1});
		queue_sample('{32'sh7FFF_FFFF, 1'b1, 1'b0});
		queue_sample('{32'sd0, 1'b1, 1'b0});
		queue_sample('{32'sh7FFF_FFFF, 1'b1, 1'b0});
		queue_sample('{32'sh8000_0000, 1'b1, 1'b0});
		queue_sample('{32'sh7FFF_FFFF, 1'b0, 1'b0});
		queue_sample('{-32'sd65536, 1'b1, 1'b0});
		queue_sample('{32'sd65536, 1'b1, 1'b0});
		queue_sample('{32'sd65536, 1'b1, 1'b0});
		queue_sample('{-32'sd65536, 1'b1, 1'b0});
		queue_sample('{-32'sd65536, 1'b1, 1'b0});
		queue_sample('{32'sd0, 1'b1, 1'b0});
		queue_sample('{32'sd30000, 1'b1, 1'b0});
		queue_sample('{-32'sd12345, 1'b1, 1'b0});
		queue_sample('{32'sd0, 1'b0, 1'b0});
		queue_sample('{32'sh8000_0000, 1'b1, 1'b0});
		queue_sample('{32'sd5, 1'b1, 1'b0});
		queue_sample('{-32'sd5, 1'b1, 1'b0});
		queue_sample('{32'sd100, 1'b1, 1'b0});
		queue_sample('{-32'sd1, 1'b1, 1'b0});
		queue_sample('{32'sd1, 1'b1, 1'b0});
		// A frame start at the beginning of a row restarts the raster.
		queue_sample('{32'sd1, 1'b1, 1'b1});
		queue_sample('{-32'sd1, 1'b1, 1'b0});
		queue_sample('{32'sd1, 1'b1, 1'b0});
		drain();

		// Two-column grid with a huge origin and step, so the x coordinates saturate.
		set_grid(32'sd4096, 32'd2, 32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd65536);
		queue_random(360, 1'b1);
		drain();

		// Now the other way round, starting with a long receiver hold-off so the
		// cell queue fills and the block stalls its input. A grid width of zero is
		// used as the minimum of two.
		send_idle_pct = 69;
		recv_idle_pct = 16;
		set_grid(-32'sd65536, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000);
		recv_hold = 800;
		queue_random(40, 1'b1);
		drain();

		// A width above the maximum is used as the maximum.
		set_grid(32'sd123456, 32'd1023, 32'd0, 32'd0, 32'd32768, 32'hFFFF_0000);
		queue_random(560, 1'b1);
		drain();

		// No idling at all. First the width shrinks in the middle of the frame: the
		// current row ends at once and later rows are seven samples wide.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_grid(32'h8000_0000, 32'd7, 32'd1000, -32'sd1000, 32'd3, 32'd7);
		queue_random(120, 1'b0);
		drain();

		set_grid(32'h7FFF_FFFF, 32'd5, 32'd0, 32'd0, 32'd65536, 32'd65536);
		queue_random(60, 1'b1);
		for (int i = 0; i < 40; i++) begin
			d.value = 32'h7FFF_FFFF - 32'($urandom_range(1));
			d.ok = 1'($urandom_range(1));
			d.first = 1'b0;
			queue_sample(d);
		end
		drain();

		// Back to random values around the reset configuration.
		set_grid(32'd0, 32'd300, 32'd0, 32'd0, 32'd65536, 32'd65536);
		queue_random(200, 1'b1);
		drain();

		if (errors == 0) begin
			$display("marching_squares_contour_tb: clean");
		end else begin
			$display("marching_squares_contour_tb: errors");
		end
		$finish;
	end

endmodule
